>>> hw/rtl/cau_pkg.sv
// shared types and codes of the complex arithmetic unit
`default_nettype none
package cau_pkg;

	localparam logic [2:0] ACT_ADD  = 3'd0;
	localparam logic [2:0] ACT_SUB  = 3'd1;
	localparam logic [2:0] ACT_MUL  = 3'd2;
	localparam logic [2:0] ACT_DIV  = 3'd3;
	localparam logic [2:0] ACT_CONJ = 3'd4;
	localparam logic [2:0] ACT_EQ   = 3'd5;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_DZ  = 2'd2;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_CONJ,
		OP_EQ,
		OP_DZ,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic signed [31:0] b_re;
		logic signed [31:0] b_im;
	} item_t;

endpackage
`default_nettype wire

>>> hw/rtl/cau_front.sv
// front end: classifies an incoming word into an operation class
`default_nettype none
module cau_front (
	input  logic [2:0]         action,
	input  logic signed [31:0] a_re,
	input  logic signed [31:0] a_im,
	input  logic signed [31:0] b_re,
	input  logic signed [31:0] b_im,
	output cau_pkg::item_t     item
);
	import cau_pkg::*;

	logic b_zero;

	assign b_zero = (b_re == 32'sd0) && (b_im == 32'sd0);

	always_comb begin
		item.a_re = a_re;
		item.a_im = a_im;
		item.b_re = b_re;
		item.b_im = b_im;
		case (action)
			ACT_ADD:  item.op = OP_ADD;
			ACT_SUB:  item.op = OP_SUB;
			ACT_MUL:  item.op = OP_MUL;
			ACT_DIV:  item.op = b_zero ? OP_DZ : OP_DIV;
			ACT_CONJ: item.op = OP_CONJ;
			ACT_EQ:   item.op = OP_EQ;
			default:  item.op = OP_NONE;
		endcase
	end

endmodule
`default_nettype wire

>>> hw/rtl/cau_fifo.sv
// two-entry queue between front end and back end
`default_nettype none
module cau_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cau_pkg::item_t wr_item,
	input  logic           pop,
	output cau_pkg::item_t rd_item,
	output logic           full,
	output logic           empty
);
	import cau_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/cau_back.sv
// back end: product, sum, magnitude and bit-per-stage quotient pipeline
`default_nettype none
module cau_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_vld,
	input  cau_pkg::item_t     head,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [31:0] res_re,
	output logic signed [31:0] res_im,
	output logic [1:0]         status,
	output logic               is_equal
);
	import cau_pkg::*;

	// quotient bits 33..0 plus one guard step that flags a huge quotient
	localparam int NQ = 35;
	localparam int RW = 98 + FRAC_BITS;

	function automatic logic [32:0] sat33(input logic signed [32:0] v);
		logic ovf;
		ovf = v[32] != v[31];
		if (ovf) begin
			return {1'b1, (v[32] ? 32'h8000_0000 : 32'h7fff_ffff)};
		end
		return {1'b0, v[31:0]};
	endfunction

	function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] mag);
		logic [31:0] lo;
		lo = mag[31:0];
		if (neg) begin
			if (mag > 64'h0000_0000_8000_0000) begin
				return {1'b1, 32'h8000_0000};
			end
			return {1'b0, (~lo) + 32'd1};
		end
		if (mag > 64'h0000_0000_7fff_ffff) begin
			return {1'b1, 32'h7fff_ffff};
		end
		return {1'b0, lo};
	endfunction

	logic adv;
	logic out_vld_q;

	assign adv = !out_vld_q || !res_stall;
	assign pop = adv && head_vld;

	// stage 1: products and the simple operations
	logic               vld_s1;
	op_t                op_s1;
	logic signed [63:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, d_rr_s1, d_ii_s1;
	logic [31:0]        re_s1, im_s1;
	logic [1:0]         st_s1;
	logic               eq_s1;

	logic [32:0] sa_re, sa_im;
	logic [31:0] c_re, c_im;
	logic [1:0]  c_st;
	logic        c_eq;

	always_comb begin
		c_re = 32'd0;
		c_im = 32'd0;
		c_st = ST_OK;
		c_eq = 1'b0;
		sa_re = 33'd0;
		sa_im = 33'd0;
		case (head.op)
			OP_ADD: begin
				sa_re = sat33($signed({head.a_re[31], head.a_re}) +
					$signed({head.b_re[31], head.b_re}));
				sa_im = sat33($signed({head.a_im[31], head.a_im}) +
					$signed({head.b_im[31], head.b_im}));
			end
			OP_SUB: begin
				sa_re = sat33($signed({head.a_re[31], head.a_re}) -
					$signed({head.b_re[31], head.b_re}));
				sa_im = sat33($signed({head.a_im[31], head.a_im}) -
					$signed({head.b_im[31], head.b_im}));
			end
			OP_CONJ: begin
				sa_re = {1'b0, head.a_re};
				sa_im = sat33(33'sd0 - $signed({head.a_im[31], head.a_im}));
			end
			OP_EQ: begin
				c_eq = (head.a_re == head.b_re) && (head.a_im == head.b_im);
			end
			OP_DZ: begin
				c_st = ST_DZ;
			end
			default: begin
			end
		endcase
		if (head.op == OP_ADD || head.op == OP_SUB || head.op == OP_CONJ) begin
			c_re = sa_re[31:0];
			c_im = sa_im[31:0];
			c_st = (sa_re[32] || sa_im[32]) ? ST_OVF : ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= head.op;
			p_rr_s1 <= head.a_re * head.b_re;
			p_ii_s1 <= head.a_im * head.b_im;
			p_ri_s1 <= head.a_re * head.b_im;
			p_ir_s1 <= head.a_im * head.b_re;
			d_rr_s1 <= head.b_re * head.b_re;
			d_ii_s1 <= head.b_im * head.b_im;
			re_s1   <= c_re;
			im_s1   <= c_im;
			st_s1   <= c_st;
			eq_s1   <= c_eq;
		end
	end

	// stage 2: numerator sums and the divisor
	logic               vld_s2;
	op_t                op_s2;
	logic signed [64:0] n_re_s2, n_im_s2;
	logic [63:0]        den_s2;
	logic [31:0]        re_s2, im_s2;
	logic [1:0]         st_s2;
	logic               eq_s2;

	logic signed [64:0] x_rr, x_ii, x_ri, x_ir;

	assign x_rr = $signed({p_rr_s1[63], p_rr_s1});
	assign x_ii = $signed({p_ii_s1[63], p_ii_s1});
	assign x_ri = $signed({p_ri_s1[63], p_ri_s1});
	assign x_ir = $signed({p_ir_s1[63], p_ir_s1});

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2 <= op_s1;
			if (op_s1 == OP_MUL) begin
				n_re_s2 <= x_rr - x_ii;
				n_im_s2 <= x_ri + x_ir;
				den_s2  <= 64'd1 << FRAC_BITS;
			end else begin
				n_re_s2 <= x_rr + x_ii;
				n_im_s2 <= x_ir - x_ri;
				den_s2  <= d_rr_s1[63:0] + d_ii_s1[63:0];
			end
			re_s2 <= re_s1;
			im_s2 <= im_s1;
			st_s2 <= st_s1;
			eq_s2 <= eq_s1;
		end
	end

	// stage 3: sign and magnitude; a product is divided by one in Q form
	logic [64:0] m_re, m_im;

	assign m_re = n_re_s2[64] ? 65'(-n_re_s2) : 65'(n_re_s2);
	assign m_im = n_im_s2[64] ? 65'(-n_im_s2) : 65'(n_im_s2);

	logic        vld_sd  [NQ+1];
	op_t         op_sd   [NQ+1];
	logic [RW-1:0] rre_sd [NQ+1];
	logic [RW-1:0] rim_sd [NQ+1];
	logic [NQ-1:0] qre_sd [NQ+1];
	logic [NQ-1:0] qim_sd [NQ+1];
	logic [63:0] den_sd  [NQ+1];
	logic        nre_sd  [NQ+1];
	logic        nim_sd  [NQ+1];
	logic [31:0] re_sd   [NQ+1];
	logic [31:0] im_sd   [NQ+1];
	logic [1:0]  st_sd   [NQ+1];
	logic        eq_sd   [NQ+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			op_sd[0]  <= op_s2;
			den_sd[0] <= den_s2;
			nre_sd[0] <= n_re_s2[64];
			nim_sd[0] <= n_im_s2[64];
			qre_sd[0] <= '0;
			qim_sd[0] <= '0;
			if (op_s2 == OP_DIV) begin
				rre_sd[0] <= {{(RW-64){1'b0}}, m_re[63:0]} << FRAC_BITS;
				rim_sd[0] <= {{(RW-64){1'b0}}, m_im[63:0]} << FRAC_BITS;
			end else begin
				rre_sd[0] <= {{(RW-64){1'b0}}, m_re[63:0]};
				rim_sd[0] <= {{(RW-64){1'b0}}, m_im[63:0]};
			end
			re_sd[0] <= re_s2;
			im_sd[0] <= im_s2;
			st_sd[0] <= st_s2;
			eq_sd[0] <= eq_s2;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar i = 0; i < NQ; i++) begin : g_div
		localparam int K = NQ - 1 - i;
		logic [RW-1:0] dsh;
		logic          ge_re, ge_im;

		assign dsh   = {{(RW-64){1'b0}}, den_sd[i]} << K;
		assign ge_re = rre_sd[i] >= dsh;
		assign ge_im = rim_sd[i] >= dsh;

		always_ff @(posedge clk) begin
			if (adv) begin
				op_sd[i+1]  <= op_sd[i];
				den_sd[i+1] <= den_sd[i];
				nre_sd[i+1] <= nre_sd[i];
				nim_sd[i+1] <= nim_sd[i];
				rre_sd[i+1] <= ge_re ? rre_sd[i] - dsh : rre_sd[i];
				rim_sd[i+1] <= ge_im ? rim_sd[i] - dsh : rim_sd[i];
				qre_sd[i+1] <= {qre_sd[i][NQ-2:0], ge_re};
				qim_sd[i+1] <= {qim_sd[i][NQ-2:0], ge_im};
				re_sd[i+1]  <= re_sd[i];
				im_sd[i+1]  <= im_sd[i];
				st_sd[i+1]  <= st_sd[i];
				eq_sd[i+1]  <= eq_sd[i];
			end
		end
	end

	// final saturation and output register
	logic [63:0] qm_re, qm_im;
	logic [32:0] f_re, f_im;

	assign qm_re = qre_sd[NQ][NQ-1] ? 64'h0000_0002_0000_0000
		: {{(64-NQ+1){1'b0}}, qre_sd[NQ][NQ-2:0]};
	assign qm_im = qim_sd[NQ][NQ-1] ? 64'h0000_0002_0000_0000
		: {{(64-NQ+1){1'b0}}, qim_sd[NQ][NQ-2:0]};
	assign f_re = sat_mag(nre_sd[NQ], qm_re);
	assign f_im = sat_mag(nim_sd[NQ], qm_im);

	logic [31:0] re_q, im_q;
	logic [1:0]  st_q;
	logic        eq_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (op_sd[NQ] == OP_MUL || op_sd[NQ] == OP_DIV) begin
				re_q <= f_re[31:0];
				im_q <= f_im[31:0];
				st_q <= (f_re[32] || f_im[32]) ? ST_OVF : ST_OK;
				eq_q <= 1'b0;
			end else begin
				re_q <= re_sd[NQ];
				im_q <= im_sd[NQ];
				st_q <= st_sd[NQ];
				eq_q <= eq_sd[NQ];
			end
		end
	end

	// valid bits of every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
			for (int j = 0; j <= NQ; j++) begin
				vld_sd[j] <= 1'b0;
			end
		end else if (adv) begin
			vld_s1    <= head_vld;
			vld_s2    <= vld_s1;
			vld_sd[0] <= vld_s2;
			for (int j = 0; j < NQ; j++) begin
				vld_sd[j+1] <= vld_sd[j];
			end
			out_vld_q <= vld_sd[NQ];
		end
	end

	assign res_valid = out_vld_q;
	assign res_re    = re_q;
	assign res_im    = im_q;
	assign status    = st_q;
	assign is_equal  = eq_q;

endmodule
`default_nettype wire

>>> hw/rtl/complex_arith_unit.sv
// complex arithmetic unit: add, sub, mul, div, conjugate and compare in Q fixed point
//
// input channel: item_valid / item_stall with action, a_re, a_im, b_re, b_im.
// a word is taken on a rising edge with item_valid high and item_stall low.
// output channel: res_valid / res_stall with res_re, res_im, status, is_equal.
// one result word leaves for every input word, in order.
// throughput: one word per cycle while res_stall does not freeze the back end; the back end is a fully pipelined chain.
// path from acceptance to res_valid: the accepting edge writes the queue,
// then product stage, sum stage, magnitude stage, 35 quotient-bit stages
// of the restoring divider, output register.
// item_stall rises when the two-entry queue behind the front end is full.
// when res_stall is high with res_valid set the whole back end freezes and
// the output word holds; the queue keeps taking words until it fills.
// reset (arst_n low) empties the queue and clears all stage valid bits;
// no result is pending after reset.
`default_nettype none
module complex_arith_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [2:0]         action,
	input  logic signed [31:0] a_re,
	input  logic signed [31:0] a_im,
	input  logic signed [31:0] b_re,
	input  logic signed [31:0] b_im,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [31:0] res_re,
	output logic signed [31:0] res_im,
	output logic [1:0]         status,
	output logic               is_equal
);
	import cau_pkg::*;

	item_t in_item;
	item_t head;
	logic  full, empty, pop, push;

	assign item_stall = full;
	assign push       = item_valid && !full;

	cau_front u_front (
		.action (action),
		.a_re   (a_re),
		.a_im   (a_im),
		.b_re   (b_re),
		.b_im   (b_im),
		.item   (in_item)
	);

	cau_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (in_item),
		.pop     (pop),
		.rd_item (head),
		.full    (full),
		.empty   (empty)
	);

	cau_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_vld  (!empty),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_re    (res_re),
		.res_im    (res_im),
		.status    (status),
		.is_equal  (is_equal)
	);

endmodule
`default_nettype wire
